// File: sv/iee_pkg.sv
// shared constants, codes and types of the ising energy evaluator
package iee_pkg;

    localparam int MAX_SPINS_DEF   = 16;
    localparam int COEFF_WIDTH_DEF = 24;
    localparam int SPINS_W         = 16;
    localparam int INDEX_W         = 8;
    localparam int VALUE_W         = 24;
    localparam int ENERGY_W        = 32;
    localparam int COUNT_W         = 5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_FIELD,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic valid;
        logic add;
        logic clear;
    } beat_t;

endpackage

// File: sv/iee_req_if.sv
// request channel: coefficient write or evaluate transaction
interface iee_req_if;

    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic [iee_pkg::INDEX_W-1:0]           coeff_index;
    logic signed [iee_pkg::VALUE_W-1:0]    coeff_value;
    logic [iee_pkg::SPINS_W-1:0]           spins;

    modport source (
        output valid,
        output cmd,
        output coeff_index,
        output coeff_value,
        output spins,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  coeff_index,
        input  coeff_value,
        input  spins,
        output ready
    );

endinterface

// File: sv/iee_res_if.sv
// result channel: energy of one evaluated configuration
interface iee_res_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [iee_pkg::ENERGY_W-1:0]   energy;

    modport source (
        output valid,
        output energy,
        input  ready
    );

    modport sink (
        input  valid,
        input  energy,
        output ready
    );

endinterface

// File: sv/ising_energy_evaluator.sv
// top level of the ising energy evaluator
//
// request channel: a transaction with cmd write stores coeff_value at coeff_index
// (couplings in pair order, then the local fields); indexes beyond the store are
// dropped. a transaction with cmd evaluate returns one energy on the result channel,
// E = -(sum of s_i*s_j*J_ij + sum of s_i*h_i) in signed Q16.16, saturated to 32 bits.
// spin_count is written through cfg_we / cfg_wdata; the user must write it while
// the block is idle, which the block itself does not enforce. an evaluate with n
// spins reads one coefficient a cycle from the single read port of the store,
// n*(n+1)/2 reads in all, and then loads the energy into the result register; the
// next request is taken once the sequencer has returned to idle.
// requests are taken only while no evaluation is running.
// the output register holds the energy while the receiver stalls; the next request
// is still taken, and a following evaluation waits at its end until the register
// is free.
// reset clears the control state and sets spin_count to sixteen; the coefficient
// store is not cleared, so every coefficient in use must be written first.
module ising_energy_evaluator #(
    parameter int MAX_SPINS   = iee_pkg::MAX_SPINS_DEF,
    parameter int COEFF_WIDTH = iee_pkg::COEFF_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    iee_req_if.sink                       request,
    iee_res_if.source                     result,
    input  logic                          cfg_we,
    input  logic [iee_pkg::COUNT_W-1:0]   cfg_wdata
);

    localparam int STORE_DEPTH = MAX_SPINS * (MAX_SPINS + 1) / 2;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = $clog2(MAX_SPINS + 1);
    localparam int ACC_W       = COEFF_WIDTH + $clog2(STORE_DEPTH) + 1;

    logic [iee_pkg::COUNT_W-1:0]   spin_count_reg;
    iee_pkg::beat_t                beat;
    logic                          load;
    logic                          out_free;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic signed [COEFF_WIDTH-1:0] wr_data;
    logic [AW-1:0]                 rd_addr;
    logic signed [COEFF_WIDTH-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_count_reg <= iee_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            spin_count_reg <= cfg_wdata;
        end
    end

    iee_seq #(
        .MAX_SPINS   (MAX_SPINS),
        .COEFF_WIDTH (COEFF_WIDTH),
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .spin_count (spin_count_reg),
        .out_free   (out_free),
        .beat       (beat),
        .load       (load),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr)
    );

    iee_coeff_mem #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (COEFF_WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (beat.valid),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    iee_accum #(
        .COEFF_WIDTH (COEFF_WIDTH),
        .ACC_W       (ACC_W)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .load     (load),
        .rd_data  (rd_data),
        .result   (result),
        .out_free (out_free)
    );

endmodule

// File: sv/iee_coeff_mem.sv
// coefficient store: one write port, one registered read port
module iee_coeff_mem #(
    parameter int DEPTH = 136,
    parameter int WIDTH = 24,
    parameter int AW    = 8
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [WIDTH-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [WIDTH-1:0] rd_data
);

    logic signed [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/iee_seq.sv
// sequencer: takes requests, walks couplings then fields, drives store addresses
module iee_seq #(
    parameter int MAX_SPINS   = 16,
    parameter int COEFF_WIDTH = 24,
    parameter int STORE_DEPTH = 136,
    parameter int AW          = 8,
    parameter int CW          = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    iee_req_if.sink                       request,
    input  logic [iee_pkg::COUNT_W-1:0]   spin_count,
    input  logic                          out_free,
    output iee_pkg::beat_t                beat,
    output logic                          load,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic signed [COEFF_WIDTH-1:0] wr_data,
    output logic [AW-1:0]                 rd_addr
);

    localparam int NCW = (CW > iee_pkg::COUNT_W) ? CW : iee_pkg::COUNT_W;

    iee_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                j_reg, j_next;
    logic [CW-1:0]                n_reg, n_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [iee_pkg::SPINS_W-1:0]  spins_reg, spins_next;

    logic                         accept;
    logic                         start;
    logic                         index_ok;
    logic [NCW-1:0]               count_ext;
    logic [NCW-1:0]               count_clamp;
    logic [CW-1:0]                n_start;
    logic [CW-1:0]                n_last;
    logic                         pair_row_end;
    logic                         pair_done;
    logic [iee_pkg::SPINS_W-1:0]  sh_i;
    logic [iee_pkg::SPINS_W-1:0]  sh_j;
    logic                         bit_i;
    logic                         bit_j;

    assign accept   = request.valid && request.ready;
    assign start    = accept && (request.cmd == iee_pkg::CMD_EVAL);
    assign index_ok = (32'(request.coeff_index) < 32'(STORE_DEPTH));

    // spin count below two acts as two, above the maximum as the maximum
    always_comb
    begin
        count_ext = NCW'(spin_count);
        if (count_ext < NCW'(2))
        begin
            count_clamp = NCW'(2);
        end
        else if (count_ext > NCW'(MAX_SPINS))
        begin
            count_clamp = NCW'(MAX_SPINS);
        end
        else
        begin
            count_clamp = count_ext;
        end
    end

    assign n_start      = CW'(count_clamp);
    assign n_last       = n_reg - CW'(1);
    assign pair_row_end = (j_reg == n_last);
    assign pair_done    = pair_row_end && ((i_reg + CW'(1)) == n_last);

    // spins beyond the field read as -1
    assign sh_i  = spins_reg >> i_reg;
    assign sh_j  = spins_reg >> j_reg;
    assign bit_i = sh_i[0];
    assign bit_j = sh_j[0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iee_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = iee_pkg::ST_PAIR;
                end
            end
            iee_pkg::ST_PAIR:
            begin
                if (pair_done)
                begin
                    state_next = iee_pkg::ST_FIELD;
                end
            end
            iee_pkg::ST_FIELD:
            begin
                if (i_reg == n_last)
                begin
                    state_next = iee_pkg::ST_DRAIN;
                end
            end
            iee_pkg::ST_DRAIN:
            begin
                state_next = iee_pkg::ST_FINISH;
            end
            iee_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = iee_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iee_pkg::ST_IDLE;
            end
        endcase
    end

    // counters
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        addr_next  = addr_reg;
        spins_next = spins_reg;
        case (state_reg)
            iee_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    j_next     = CW'(1);
                    addr_next  = '0;
                    n_next     = n_start;
                    spins_next = request.spins;
                end
            end
            iee_pkg::ST_PAIR:
            begin
                addr_next = addr_reg + AW'(1);
                if (pair_done)
                begin
                    i_next = '0;
                end
                else if (pair_row_end)
                begin
                    i_next = i_reg + CW'(1);
                    j_next = i_reg + CW'(2);
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            iee_pkg::ST_FIELD:
            begin
                addr_next = addr_reg + AW'(1);
                i_next    = i_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        request.ready = (state_reg == iee_pkg::ST_IDLE);
        beat.valid    = (state_reg == iee_pkg::ST_PAIR) || (state_reg == iee_pkg::ST_FIELD);
        beat.add      = (state_reg == iee_pkg::ST_PAIR) ? (bit_i == bit_j) : bit_i;
        beat.clear    = start;
        load          = (state_reg == iee_pkg::ST_FINISH) && out_free;
        wr_en         = accept && (request.cmd == iee_pkg::CMD_WRITE) && index_ok;
        wr_addr       = AW'(request.coeff_index);
        wr_data       = COEFF_WIDTH'(request.coeff_value);
        rd_addr       = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iee_pkg::ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= CW'(2);
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spins_reg <= spins_next;
    end

    a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        beat.valid |-> (32'(rd_addr) < 32'(STORE_DEPTH)))
        else $error("store address beyond depth");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iee_pkg::ST_PAIR) |-> ((j_reg > i_reg) && (j_reg < n_reg)))
        else $error("pair indices out of order");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == iee_pkg::ST_FIELD) |-> (i_reg < n_reg))
        else $error("field index beyond spin count");

    a_start_walk: assert property (@(posedge clk) disable iff (!rst_n)
        beat.clear |=> ((state_reg == iee_pkg::ST_PAIR) && (addr_reg == '0)))
        else $error("evaluation did not start at address zero");

endmodule

// File: sv/iee_accum.sv
// accumulator: signed add or subtract of each coefficient, negate, saturate, output register
module iee_accum #(
    parameter int COEFF_WIDTH = 24,
    parameter int ACC_W       = 33
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iee_pkg::beat_t                beat,
    input  logic                          load,
    input  logic signed [COEFF_WIDTH-1:0] rd_data,
    iee_res_if.source                     result,
    output logic                          out_free
);

    localparam int NW = (ACC_W + 1 > iee_pkg::ENERGY_W) ? ACC_W + 1 : iee_pkg::ENERGY_W + 1;
    localparam logic signed [NW-1:0] E_MAX = NW'(32'sh7FFF_FFFF);
    localparam logic signed [NW-1:0] E_MIN = NW'(32'sh8000_0000);

    logic                                  stage_valid_reg;
    logic                                  stage_add_reg;
    logic signed [ACC_W-1:0]               acc_reg, acc_next;
    logic signed [ACC_W-1:0]               term;
    logic signed [NW-1:0]                  neg;
    logic signed [iee_pkg::ENERGY_W-1:0]   energy_next;
    logic signed [iee_pkg::ENERGY_W-1:0]   energy_reg;
    logic                                  out_valid_reg, out_valid_next;

    assign term = ACC_W'(rd_data);

    always_comb
    begin
        acc_next = acc_reg;
        if (beat.clear)
        begin
            acc_next = '0;
        end
        else if (stage_valid_reg)
        begin
            acc_next = stage_add_reg ? (acc_reg + term) : (acc_reg - term);
        end
    end

    // energy is the negated sum, held to the 32-bit range
    always_comb
    begin
        neg = -NW'(acc_reg);
        if (neg > E_MAX)
        begin
            energy_next = iee_pkg::ENERGY_W'(E_MAX);
        end
        else if (neg < E_MIN)
        begin
            energy_next = iee_pkg::ENERGY_W'(E_MIN);
        end
        else
        begin
            energy_next = iee_pkg::ENERGY_W'(neg);
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.energy = energy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= beat.valid;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_add_reg <= beat.add;
        acc_reg       <= acc_next;
        if (load)
        begin
            energy_reg <= energy_next;
        end
    end

endmodule

// File: tb/iee_energy_checker.sv
// energy checker: mirrors the coefficient store and spin count, predicts and compares energies
module iee_energy_checker
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    iee_req_if                 request,
    iee_res_if                 result,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    output int                 mismatches,
    output int                 outstanding,
    output int                 energies_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_SPINS_DEF * (MAX_SPINS_DEF + 1) / 2;

    logic signed [VALUE_W-1:0]  coeff_mem [STORE_DEPTH];
    logic [COUNT_W-1:0]         spin_setting;
    logic signed [ENERGY_W-1:0] energy_q [$];
    logic signed [ENERGY_W-1:0] want;
    int                         fail_count = 0;
    int                         checked_count = 0;
    int                         pending_count = 0;

    assign mismatches       = fail_count;
    assign outstanding      = pending_count;
    assign energies_checked = checked_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] energy mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic signed [ENERGY_W-1:0] predict_energy(input logic [SPINS_W-1:0] s);
        int     n;
        int     base;
        int     addr;
        int     i;
        int     j;
        longint acc;
        n = (spin_setting < 2) ? 2 :
            (spin_setting > MAX_SPINS_DEF) ? MAX_SPINS_DEF : int'(spin_setting);
        base = n * (n - 1) / 2;
        addr = 0;
        acc = 0;
        for (i = 0; i < n; i++)
        begin
            for (j = i + 1; j < n; j++)
            begin
                if (s[i] == s[j])
                    acc += coeff_mem[addr];
                else
                    acc -= coeff_mem[addr];
                addr++;
            end
            if (s[i])
                acc += coeff_mem[base + i];
            else
                acc -= coeff_mem[base + i];
        end
        acc = -acc;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[ENERGY_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_setting = COUNT_RESET;
            energy_q.delete();
            pending_count = 0;
        end
        else
        begin
            // results leave before the request of this edge can add one
            if (result.valid && result.ready)
            begin
                if (energy_q.size() == 0)
                    report_mismatch($sformatf("energy %0d with no evaluation waiting",
                                              result.energy));
                else
                begin
                    want = energy_q.pop_front();
                    checked_count++;
                    if (result.energy !== want)
                        report_mismatch($sformatf("got %0d, want %0d", result.energy, want));
                end
            end
            if (request.valid && request.ready)
            begin
                if (request.cmd == CMD_EVAL)
                    energy_q.push_back(predict_energy(request.spins));
                else if (request.coeff_index < STORE_DEPTH)
                    coeff_mem[request.coeff_index] = request.coeff_value;
            end
            if (cfg_we)
                spin_setting = cfg_wdata;
            pending_count = energy_q.size();
        end
    end

endmodule

// File: tb/tb_ising_energy_evaluator.sv
// testbench top: drives coefficient writes, evaluations and spin counts, gives the verdict
module tb_ising_energy_evaluator;
    timeunit 1ns;
    timeprecision 1ps;

    import iee_pkg::*;

    localparam int STORE_DEPTH   = MAX_SPINS_DEF * (MAX_SPINS_DEF + 1) / 2;
    localparam int SETTLE_CYCLES = 160;
    localparam int LONG_HOLD     = 1200;
    localparam int PHASE_ITEMS   = 45;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int                 mismatches;
    int                 outstanding;
    int                 energies_checked;
    int                 spin_setting = COUNT_RESET;
    int                 sent_items = 0;
    int                 sent_evals = 0;
    int                 settings_done = 0;
    int                 taken = 0;
    bit                 send_calm = 1'b0;
    bit                 take_calm = 1'b0;

    iee_req_if req_ch ();
    iee_res_if res_ch ();

    ising_energy_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    iee_energy_checker energy_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .request          (req_ch),
        .result           (res_ch),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .energies_checked (energies_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            default: return VALUE_W'($urandom());
        endcase
    endfunction

    task automatic push_request(input logic op, input logic [INDEX_W-1:0] idx,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [SPINS_W-1:0] sp);
        int gap;
        if ($urandom_range(0, 24) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.coeff_index <= idx;
        req_ch.coeff_value <= val;
        req_ch.spins       <= sp;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_items++;
        if (op == CMD_EVAL)
            sent_evals++;
    endtask

    task automatic write_coeff(input int idx, input logic signed [VALUE_W-1:0] val);
        push_request(CMD_WRITE, INDEX_W'(idx), val, SPINS_W'($urandom()));
    endtask

    task automatic evaluate(input logic [SPINS_W-1:0] sp);
        push_request(CMD_EVAL, INDEX_W'($urandom()), VALUE_W'($urandom()), sp);
    endtask

    // waits until every energy is back and the block has gone quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_spin_count(input int v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        spin_setting = v;
        settings_done++;
    endtask

    task automatic random_phase(input int count);
        int n_eff;
        int in_use;
        int roll;
        int k;
        n_eff = (spin_setting < 2) ? 2 :
                (spin_setting > MAX_SPINS_DEF) ? MAX_SPINS_DEF : spin_setting;
        in_use = n_eff * (n_eff + 1) / 2;
        for (k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                case ($urandom_range(0, 15))
                    0:       evaluate('0);
                    1:       evaluate('1);
                    default: evaluate(SPINS_W'($urandom()));
                endcase
            end
            else if (roll < 85)
                write_coeff($urandom_range(0, in_use - 1), pick_value());
            else
                write_coeff($urandom_range(0, 255), pick_value());
        end
    endtask

    // receiver: random stalls, two long hold-offs so the block backs up
    initial
    begin
        int gap;
        forever
        begin
            if ($urandom_range(0, 24) == 0)
                take_calm = !take_calm;
            if (taken == 60 || taken == 120)
                gap = LONG_HOLD;
            else
                gap = take_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        int i;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= CMD_WRITE;
        req_ch.coeff_index <= '0;
        req_ch.coeff_value <= '0;
        req_ch.spins       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store at the largest value, spin count left at reset
        for (i = 0; i < STORE_DEPTH; i++)
            write_coeff(i, VALUE_MAX);
        evaluate('1);
        evaluate('0);
        evaluate(16'hAAAA);
        evaluate(16'h5555);

        // writes past the store are dropped
        write_coeff(STORE_DEPTH, '0);
        write_coeff(255, VALUE_MIN);
        evaluate('1);
        write_coeff(0, VALUE_MIN);
        write_coeff(STORE_DEPTH - 1, VALUE_MIN);
        evaluate(16'h8001);
        evaluate(16'h7FFE);

        // spin counts below two act as two, above the maximum act as the maximum
        set_spin_count(0);
        write_coeff(0, VALUE_MIN);
        write_coeff(1, VALUE_MIN);
        write_coeff(2, VALUE_MIN);
        evaluate(16'h0000);
        evaluate(16'h0001);
        evaluate(16'h0002);
        evaluate(16'hFFFC);
        set_spin_count(1);
        evaluate(16'hFFFE);
        set_spin_count(31);
        evaluate('1);
        evaluate(16'h1234);
        set_spin_count(17);
        evaluate(16'h8000);

        set_spin_count(16);
        random_phase(PHASE_ITEMS);
        set_spin_count(2);
        random_phase(PHASE_ITEMS);
        set_spin_count($urandom_range(3, 15));
        random_phase(PHASE_ITEMS);
        set_spin_count(31);
        random_phase(PHASE_ITEMS);
        set_spin_count(0);
        random_phase(PHASE_ITEMS / 2);
        set_spin_count($urandom_range(0, 31));
        random_phase(PHASE_ITEMS);
        set_spin_count(MAX_SPINS_DEF);
        random_phase(PHASE_ITEMS);
        settle();

        $display("summary: %0d requests, %0d evaluations, %0d spin-count settings (0..31)",
                 sent_items, sent_evals, settings_done);
        $display("summary: %0d energies checked, %0d mismatches, two long result stalls",
                 energies_checked, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d energies outstanding", outstanding);
        $display("tb: failure");
        $finish;
    end

endmodule
